// ===== rtl/core/indexed_list_store_assert.svh =====
// Assertion macros for the indexed list store.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define ILS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ILS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ils_pkg.sv =====
// Shared constants, codes and controller/datapath command types for the list store.
// No dependencies.
package ils_pkg;

    localparam int DEPTH  = 64;
    localparam int ELEM_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OP_W   = 4;
    localparam int IDX_W  = 7;
    localparam int POS_W  = 6;
    localparam int ST_W   = 2;
    // common width for index/count/pointer compares
    localparam int CMP_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 4'd0,
        OP_GET      = 4'd1,
        OP_SET      = 4'd2,
        OP_INSERT   = 4'd3,
        OP_REMOVE   = 4'd4,
        OP_POP      = 4'd5,
        OP_CONTAINS = 4'd6,
        OP_INDEX_OF = 4'd7,
        OP_CLEAR    = 4'd8
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_ZERO_ELEM = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TAKE,
        S_INS,
        S_DN,
        S_SRCH,
        S_FIN
    } t_state;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_APPEND,
        ACT_SET,
        ACT_CLEAR,
        ACT_RD_IDX,
        ACT_TAKE_GOT,
        ACT_INS_START,
        ACT_INS_STEP,
        ACT_INS_LAST,
        ACT_DN_STEP,
        ACT_DN_LAST,
        ACT_SRCH_START,
        ACT_SRCH_STEP,
        ACT_PUBLISH
    } t_act;

    typedef struct packed {
        t_act    act;
        logic    st_we;
        t_status st;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            zero_elem;
        logic            idx_lt_cnt;
        logic            idx_le_cnt;
        logic            full;
        logic            ins_end;
        logic            fwd_end;
        logic            found;
        logic            out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/ils_chan_if.sv =====
// Valid/ready channel interfaces for the list store request and result.
// Depends on ils_pkg for field widths.
interface ils_in_if;
    logic                       valid;
    logic                       ready;
    logic [ils_pkg::OP_W-1:0]   op;
    logic [ils_pkg::IDX_W-1:0]  index;
    logic [ils_pkg::ELEM_W-1:0] element;

    modport source (output valid, output op, output index, output element, input ready);
    modport sink   (input valid, input op, input index, input element, output ready);
endinterface

interface ils_out_if;
    logic                       valid;
    logic                       ready;
    logic [ils_pkg::ST_W-1:0]   status;
    logic [ils_pkg::ELEM_W-1:0] element_out;
    logic                       found;
    logic [ils_pkg::POS_W-1:0]  position;
    logic [ils_pkg::CNT_W-1:0]  count;
    logic                       empty_res;

    modport source (output valid, output status, output element_out, output found,
                    output position, output count, output empty_res, input ready);
    modport sink   (input valid, input status, input element_out, input found,
                    input position, input count, input empty_res, output ready);
endinterface

// ===== rtl/core/ils_ctrl.sv =====
// Controller FSM: checks each request and sequences the datapath walks.
// Depends on ils_pkg.
module ils_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ils_pkg::t_dp_stat i_stat,
    output ils_pkg::t_dp_cmd  o_cmd
);
    import ils_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                unique case (i_stat.op)
                    OP_GET: begin
                        n_state = i_stat.idx_lt_cnt ? S_TAKE : S_FIN;
                    end
                    OP_REMOVE, OP_POP: begin
                        n_state = i_stat.idx_lt_cnt ? S_TAKE : S_FIN;
                    end
                    OP_INSERT: begin
                        n_state = (i_stat.idx_le_cnt && !i_stat.full) ? S_INS : S_FIN;
                    end
                    OP_CONTAINS, OP_INDEX_OF: begin
                        n_state = i_stat.zero_elem ? S_FIN : S_SRCH;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_TAKE: begin
                n_state = (i_stat.op == OP_GET) ? S_FIN : S_DN;
            end
            S_INS: begin
                if (i_stat.ins_end) n_state = S_FIN;
            end
            S_DN: begin
                if (i_stat.fwd_end) n_state = S_FIN;
            end
            S_SRCH: begin
                if (i_stat.found || i_stat.fwd_end) n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd.act   = ACT_NONE;
        o_cmd.st_we = 1'b0;
        o_cmd.st    = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.act = ACT_LOAD;
            end
            S_CHECK: begin
                unique case (i_stat.op)
                    OP_APPEND: begin
                        if (i_stat.zero_elem) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = ST_ZERO_ELEM;
                        end else if (i_stat.full) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = ST_FULL;
                        end else begin
                            o_cmd.act = ACT_APPEND;
                        end
                    end
                    OP_SET: begin
                        if (i_stat.zero_elem) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = ST_ZERO_ELEM;
                        end else if (!i_stat.idx_lt_cnt) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = ST_BAD_INDEX;
                        end else begin
                            o_cmd.act = ACT_SET;
                        end
                    end
                    OP_GET, OP_REMOVE, OP_POP: begin
                        if (!i_stat.idx_lt_cnt) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = ST_BAD_INDEX;
                        end else begin
                            o_cmd.act = ACT_RD_IDX;
                        end
                    end
                    OP_INSERT: begin
                        if (!i_stat.idx_le_cnt) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = ST_BAD_INDEX;
                        end else if (i_stat.full) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = ST_FULL;
                        end else begin
                            o_cmd.act = ACT_INS_START;
                        end
                    end
                    OP_CONTAINS, OP_INDEX_OF: begin
                        if (i_stat.zero_elem) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = ST_ZERO_ELEM;
                        end else begin
                            o_cmd.act = ACT_SRCH_START;
                        end
                    end
                    OP_CLEAR: o_cmd.act = ACT_CLEAR;
                    default:  o_cmd.act = ACT_NONE;
                endcase
            end
            S_TAKE: begin
                // remove drops the read handle, get and pop return it
                if (i_stat.op != OP_REMOVE) o_cmd.act = ACT_TAKE_GOT;
            end
            S_INS: begin
                o_cmd.act = i_stat.ins_end ? ACT_INS_LAST : ACT_INS_STEP;
            end
            S_DN: begin
                o_cmd.act = i_stat.fwd_end ? ACT_DN_LAST : ACT_DN_STEP;
            end
            S_SRCH: begin
                if (!(i_stat.found || i_stat.fwd_end)) o_cmd.act = ACT_SRCH_STEP;
            end
            S_FIN: begin
                if (i_stat.out_free) o_cmd.act = ACT_PUBLISH;
            end
            default: o_cmd.act = ACT_NONE;
        endcase
    end

endmodule

// ===== rtl/core/ils_datapath.sv =====
// Datapath: entry memory, count, request and result registers, walk pointers.
// Depends on ils_pkg; driven by the ils_ctrl command struct.
module ils_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ils_pkg::t_dp_cmd           i_cmd,
    output ils_pkg::t_dp_stat          o_stat,
    input  logic [ils_pkg::OP_W-1:0]   i_op,
    input  logic [ils_pkg::IDX_W-1:0]  i_index,
    input  logic [ils_pkg::ELEM_W-1:0] i_element,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ils_pkg::ST_W-1:0]   o_status,
    output logic [ils_pkg::ELEM_W-1:0] o_element_out,
    output logic                       o_found,
    output logic [ils_pkg::POS_W-1:0]  o_position,
    output logic [ils_pkg::CNT_W-1:0]  o_count,
    output logic                       o_empty_res
);
    import ils_pkg::*;

    // entry store, no reset: reads always lie below the count
    logic [ELEM_W-1:0] r_mem [DEPTH];
    logic [ELEM_W-1:0] r_rdata;

    // request
    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [ELEM_W-1:0] r_elem;

    // list state and walk
    logic [CNT_W-1:0]  r_count;
    logic [CMP_W-1:0]  r_ptr;
    logic [CMP_W-1:0]  r_wptr;
    logic              r_wpend;

    // result being built
    t_status           r_st;
    logic [ELEM_W-1:0] r_got;
    logic              r_fnd;
    logic [POS_W-1:0]  r_pos;

    logic [CMP_W-1:0]  w_idx_x;
    logic [CMP_W-1:0]  w_cnt_x;
    logic              w_out_free;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ELEM_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    assign w_idx_x    = CMP_W'(r_idx);
    assign w_cnt_x    = CMP_W'(r_count);
    assign w_out_free = !o_out_valid || i_out_ready;

    // status to the controller
    always_comb begin
        o_stat.op         = r_op;
        o_stat.zero_elem  = (r_elem == '0);
        o_stat.idx_lt_cnt = (w_idx_x < w_cnt_x);
        o_stat.idx_le_cnt = (w_idx_x <= w_cnt_x);
        o_stat.full       = (w_cnt_x == CMP_W'(DEPTH));
        o_stat.ins_end    = !r_wpend && (r_ptr <= w_idx_x);
        o_stat.fwd_end    = !r_wpend && (r_ptr >= w_cnt_x);
        o_stat.found      = r_fnd;
        o_stat.out_free   = w_out_free;
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(r_wptr);
        mem_wdata = r_rdata;
        mem_re    = 1'b0;
        mem_raddr = ADDR_W'(r_ptr);
        unique case (i_cmd.act)
            ACT_APPEND: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(r_count);
                mem_wdata = r_elem;
            end
            ACT_SET, ACT_INS_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(r_idx);
                mem_wdata = r_elem;
            end
            ACT_RD_IDX: begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(r_idx);
            end
            ACT_INS_STEP: begin
                // shift up: read below the pointer, write the previous read above it
                mem_we    = r_wpend;
                mem_re    = (r_ptr > w_idx_x);
                mem_raddr = ADDR_W'(r_ptr - CMP_W'(1));
            end
            ACT_DN_STEP: begin
                // shift down: read at the pointer, write the previous read below it
                mem_we = r_wpend;
                mem_re = (r_ptr < w_cnt_x);
            end
            ACT_SRCH_STEP: begin
                mem_re = (r_ptr < w_cnt_x);
            end
            default: begin
                mem_we = 1'b0;
                mem_re = 1'b0;
            end
        endcase
    end

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    // request, walk and result registers; only control state is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_wpend     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd.act)
                ACT_LOAD: begin
                    r_op   <= i_op;
                    r_idx  <= i_index;
                    r_elem <= i_element;
                    r_st   <= ST_OK;
                    r_got  <= '0;
                    r_fnd  <= 1'b0;
                    r_pos  <= '0;
                end
                ACT_APPEND: r_count <= r_count + CNT_W'(1);
                ACT_CLEAR:  r_count <= '0;
                ACT_RD_IDX: begin
                    r_ptr   <= w_idx_x + CMP_W'(1);
                    r_wpend <= 1'b0;
                end
                ACT_TAKE_GOT: r_got <= r_rdata;
                ACT_INS_START: begin
                    r_ptr   <= w_cnt_x;
                    r_wpend <= 1'b0;
                end
                ACT_INS_STEP: begin
                    if (r_ptr > w_idx_x) begin
                        r_wptr  <= r_ptr;
                        r_ptr   <= r_ptr - CMP_W'(1);
                        r_wpend <= 1'b1;
                    end else begin
                        r_wpend <= 1'b0;
                    end
                end
                ACT_INS_LAST: r_count <= r_count + CNT_W'(1);
                ACT_DN_STEP: begin
                    if (r_ptr < w_cnt_x) begin
                        r_wptr  <= r_ptr - CMP_W'(1);
                        r_ptr   <= r_ptr + CMP_W'(1);
                        r_wpend <= 1'b1;
                    end else begin
                        r_wpend <= 1'b0;
                    end
                end
                ACT_DN_LAST: r_count <= r_count - CNT_W'(1);
                ACT_SRCH_START: begin
                    r_ptr   <= '0;
                    r_wpend <= 1'b0;
                end
                ACT_SRCH_STEP: begin
                    // compare last read; keep the first match only
                    if (r_wpend && !r_fnd && (r_rdata == r_elem)) begin
                        r_fnd <= 1'b1;
                        r_pos <= POS_W'(r_wptr);
                    end
                    if (r_ptr < w_cnt_x) begin
                        r_wptr  <= r_ptr;
                        r_ptr   <= r_ptr + CMP_W'(1);
                        r_wpend <= 1'b1;
                    end else begin
                        r_wpend <= 1'b0;
                    end
                end
                default: ;
            endcase

            if (i_cmd.st_we) r_st <= i_cmd.st;

            // output register
            if (i_cmd.act == ACT_PUBLISH) begin
                o_out_valid   <= 1'b1;
                o_status      <= r_st;
                o_element_out <= r_got;
                o_found       <= r_fnd;
                o_position    <= r_pos;
                o_count       <= r_count;
                o_empty_res   <= (r_count == '0);
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/indexed_list_store.sv =====
// Top level of the indexed list store: controller, datapath and assertions.
// Depends on ils_pkg, ils_chan_if, ils_ctrl, ils_datapath and the assertion header.
//
// Usage:
//   i_in carries one request (op, index, element) per transfer; o_out carries
//   exactly one result (status, element_out, found, position, count,
//   empty_res) per request, in request order.
//   One request is in work at a time. Contains and index_of end their walk
//   early on a match. The entry walk of the memory moves one entry per
//   cycle; the next request is taken in the cycle after its result is
//   loaded into the output register.
//   The output register parts the two sides: a stalled receiver holds its
//   result while the next request is accepted and worked on; that request's
//   result waits until the output register is taken.
//   Reset (synchronous, active low) empties the list and drops any pending
//   result. The entry memory is not cleared; no read ever lies above count.
module indexed_list_store (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ils_in_if.sink    i_in,
    ils_out_if.source o_out
);
    import ils_pkg::*;

    `include "indexed_list_store_assert.svh"

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_in.ready = w_in_ready;

    // sequencing
    ils_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // storage and result
    ils_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_op          (i_in.op),
        .i_index       (i_in.index),
        .i_element     (i_in.element),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_status      (o_out.status),
        .o_element_out (o_out.element_out),
        .o_found       (o_out.found),
        .o_position    (o_out.position),
        .o_count       (o_out.count),
        .o_empty_res   (o_out.empty_res)
    );

    // a new result never overwrites one still waiting
    `ILS_ASSERT_IMP(a_pub_free, w_cmd.act == ACT_PUBLISH, !o_out.valid || o_out.ready, "result lost")
    // output valid only rises through a publish
    `ILS_ASSERT_IMP(a_valid_src, $rose(o_out.valid), $past(w_cmd.act == ACT_PUBLISH), "stray valid")
    // reported count never exceeds capacity
    `ILS_ASSERT_IMP(a_cnt_cap, o_out.valid, o_out.count <= CNT_W'(DEPTH), "count over capacity")
    // one request at a time
    `ILS_ASSERT_NXT(a_one_req, i_in.valid && i_in.ready, !i_in.ready, "second request taken")

endmodule
